// ----- sv/blca_pkg.sv -----
// ----------------------------------------------------------------------------
// blca_pkg
// Shared types and constants of the binary lifting ancestor engine: node id
// width, register map, request codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package blca_pkg;

   localparam int ID_W   = 10;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   // register index, taken from paddr[2]
   localparam logic REG_NODE_COUNT = 1'b0;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic take_req;
      logic swap;
      logic k_init;
      logic up_step;
      logic eq_chk;
      logic both_step;
      logic out_load;
      logic load_wr;
      logic bld_start;
      logic bld_mid;
      logic bld_wr;
      logic clr_wr;
   } blca_cmd_type;

   typedef struct packed {
      logic du_lt_dv;
      logic k_zero;
      logic u_eq_v;
      logic bld_empty;
      logic i_last;
      logic bld_done;
      logic clr_done;
   } blca_sts_type;

endpackage

// ----- sv/binary_lifting_lca.sv -----
// ----------------------------------------------------------------------------
// binary_lifting_lca
// Lowest common ancestor engine with a binary lifting jump table. Software
// loads each node with its parent (0 for the root) and depth (root is 1);
// the load request flagged last_entry then builds the upper table levels for
// nodes 1..node_count, capped at MAX_NODES-1. A query returns the lowest
// common ancestor of two nodes, one response per query and none per load.
// After reset the jump table is cleared one node row per cycle, with
// req_stall high. A query response turns valid in the cycle req_stall
// drops; the second lifting pass is skipped when one node is an ancestor of
// the other. Each of the two lifting passes walks one level per cycle
// through the registered read of the jump table row. A build makes two
// table accesses per node and level. Requests are taken one at a time; a
// finished response may wait in the output register while the next request
// enters, and a query that finishes while that response is still stalled
// holds until it leaves.
// ----------------------------------------------------------------------------
module binary_lifting_lca
   import blca_pkg::*;
#(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic [ID_W-1:0]   req_node_a,
   input  logic [ID_W-1:0]   req_node_b,
   input  logic [ID_W-1:0]   req_node_depth,
   input  logic              req_last_entry,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ID_W-1:0]   rsp_ancestor,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   blca_cmd_type    cmd;
   blca_sts_type    sts;
   logic [ID_W-1:0] node_count_ff, node_count_in;
   logic            csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT);
   assign node_count_in = csr_wr ? pwdata[ID_W-1:0] : node_count_ff;
   assign prdata = (paddr[2] == REG_NODE_COUNT) ? DATA_W'(node_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= ID_W'(1);
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   blca_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_mode       (req_mode),
      .req_last_entry (req_last_entry),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .sts            (sts),
      .cmd            (cmd)
   );

   blca_dpath #(
      .MAX_NODES   (MAX_NODES),
      .LIFT_LEVELS (LIFT_LEVELS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .node_count     (node_count_ff),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .req_node_depth (req_node_depth),
      .rsp_ancestor   (rsp_ancestor)
   );

`ifndef NO_ASSERTIONS
   // only one source drives the jump table write port
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_wr, cmd.load_wr, cmd.bld_wr}))
      else $error("jump table write port driven by more than one source");

   // a response is never overwritten while it waits
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("response register loaded while full and stalled");

   // the engine is busy in the cycle after a request is accepted
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one still in work");

   // no request is taken as the clearing pass begins after reset
   assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("request port open during clearing pass");
`endif

endmodule

// ----- sv/blca_ctrl.sv -----
// ----------------------------------------------------------------------------
// blca_ctrl
// Sequencer of the ancestor engine: clearing pass, loads, jump table build
// and the two lifting passes of a query; owns the result valid flag.
// ----------------------------------------------------------------------------
module blca_ctrl
   import blca_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_mode,
   input  logic         req_last_entry,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  blca_sts_type sts,
   output blca_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWAP,
      ST_UP,
      ST_EQ,
      ST_BOTH,
      ST_FIN,
      ST_LOAD,
      ST_BRD,
      ST_BMID,
      ST_BWR
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               last_in      = req_last_entry;
               state_in     = (req_mode == MODE_QUERY) ? ST_SWAP : ST_LOAD;
            end
         end
         ST_SWAP: begin
            cmd.swap   = 1'b1;
            cmd.k_init = 1'b1;
            state_in   = ST_UP;
         end
         ST_UP: begin
            cmd.up_step = 1'b1;
            if (sts.k_zero) begin
               state_in = ST_EQ;
            end
         end
         ST_EQ: begin
            cmd.eq_chk = 1'b1;
            if (sts.u_eq_v) begin
               state_in = ST_FIN;
            end else begin
               cmd.k_init = 1'b1;
               state_in   = ST_BOTH;
            end
         end
         ST_BOTH: begin
            cmd.both_step = 1'b1;
            if (sts.k_zero) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.load_wr = 1'b1;
            if (last_ff && !sts.bld_empty) begin
               cmd.bld_start = 1'b1;
               state_in      = ST_BRD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         // re-read the row after a write that may have hit it
         ST_BRD: begin
            state_in = ST_BMID;
         end
         ST_BMID: begin
            cmd.bld_mid = 1'b1;
            state_in    = ST_BWR;
         end
         ST_BWR: begin
            cmd.bld_wr = 1'b1;
            if (sts.bld_done) begin
               state_in = ST_IDLE;
            end else if (sts.i_last) begin
               state_in = ST_BRD;
            end else begin
               state_in = ST_BMID;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- sv/blca_dpath.sv -----
// ----------------------------------------------------------------------------
// blca_dpath
// Datapath of the ancestor engine: jump table and depth memories, the two
// walking node registers, level counters and the result register.
// ----------------------------------------------------------------------------
module blca_dpath
   import blca_pkg::*;
#(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  blca_cmd_type     cmd,
   output blca_sts_type     sts,
   input  logic [ID_W-1:0]  node_count,
   input  logic [ID_W-1:0]  req_node_a,
   input  logic [ID_W-1:0]  req_node_b,
   input  logic [ID_W-1:0]  req_node_depth,
   output logic [ID_W-1:0]  rsp_ancestor
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int KW = $clog2(LIFT_LEVELS);
   localparam int CW = ((LIFT_LEVELS > ID_W) ? LIFT_LEVELS : ID_W) + 1;
   localparam logic [KW-1:0] K_TOP = KW'(LIFT_LEVELS - 1);

   typedef logic [LIFT_LEVELS-1:0][ID_W-1:0] row_type;

   function automatic logic [ID_W-1:0] to_node(input logic [ID_W-1:0] x);
      return (int'(x) < MAX_NODES) ? x : '0;
   endfunction

   function automatic logic [AW-1:0] to_addr(input logic [ID_W-1:0] x);
      return AW'(x);
   endfunction

   row_type         jump_mem [MAX_NODES];
   logic [ID_W-1:0] depth_mem [MAX_NODES];

   // u doubles as the node counter during the build, v as the ancestor that u's previous table level names there
   logic [ID_W-1:0] u_ff, u_in, v_ff, v_in;
   logic [KW-1:0]   k_ff, k_in, lvl_ff, lvl_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [ID_W-1:0] dep_ff, dep_in;
   logic            eq_ff, eq_in;
   logic [ID_W-1:0] anc_ff, anc_in;
   row_type         row_u_ff, row_v_ff;
   logic [ID_W-1:0] du_rd_ff, dv_rd_ff;

   logic [ID_W-1:0] du, dv, au, av, top, mid, up_val;
   logic [KW-1:0]   lvl_prev;
   logic            lift_ok;
   logic            wr_en, dwr_en;
   logic [AW-1:0]   wr_addr;
   row_type         wr_row;

   // node 0 is "none" and has depth 0
   assign du = (u_ff == '0) ? '0 : du_rd_ff;
   assign dv = (v_ff == '0) ? '0 : dv_rd_ff;

   assign lift_ok  = CW'(du) >= (CW'(dv) + (CW'(1) << k_ff));
   assign au       = to_node(row_u_ff[k_ff]);
   assign av       = to_node(row_v_ff[k_ff]);
   assign top      = (int'(node_count) > MAX_NODES - 1) ? ID_W'(MAX_NODES - 1) : node_count;
   assign lvl_prev = lvl_ff - KW'(1);
   assign mid      = to_node(row_u_ff[lvl_prev]);
   assign up_val   = (v_ff != '0) ? row_v_ff[lvl_prev] : '0;

   assign sts.du_lt_dv  = du < dv;
   assign sts.k_zero    = (k_ff == '0);
   assign sts.u_eq_v    = (u_ff == v_ff);
   assign sts.bld_empty = (top == '0);
   assign sts.i_last    = (u_ff == top);
   assign sts.bld_done  = (u_ff == top) && (lvl_ff == K_TOP);
   assign sts.clr_done  = (clr_ff == AW'(MAX_NODES - 1));

   assign rsp_ancestor = anc_ff;

   always_comb begin
      u_in    = u_ff;
      v_in    = v_ff;
      k_in    = k_ff;
      lvl_in  = lvl_ff;
      clr_in  = clr_ff;
      dep_in  = dep_ff;
      eq_in   = eq_ff;
      anc_in  = anc_ff;
      wr_en   = 1'b0;
      dwr_en  = 1'b0;
      wr_addr = to_addr(u_ff);
      wr_row  = row_u_ff;
      if (cmd.take_req) begin
         u_in   = to_node(req_node_a);
         v_in   = to_node(req_node_b);
         dep_in = req_node_depth;
      end
      if (cmd.swap && sts.du_lt_dv) begin
         u_in = v_ff;
         v_in = u_ff;
      end
      if (cmd.k_init) begin
         k_in = K_TOP;
      end
      if (cmd.up_step) begin
         if (lift_ok) begin
            u_in = au;
         end
         k_in = k_ff - KW'(1);
      end
      if (cmd.eq_chk) begin
         eq_in = (u_ff == v_ff);
      end
      if (cmd.both_step) begin
         if (au != '0 && au != av) begin
            u_in = au;
            v_in = av;
         end
         k_in = k_ff - KW'(1);
      end
      if (cmd.out_load) begin
         anc_in = eq_ff ? u_ff : to_node(row_u_ff[0]);
      end
      if (cmd.load_wr) begin
         wr_en     = (u_ff != '0);
         dwr_en    = (u_ff != '0);
         wr_row[0] = v_ff;
      end
      if (cmd.bld_start) begin
         u_in   = ID_W'(1);
         lvl_in = KW'(1);
      end
      if (cmd.bld_mid) begin
         v_in = mid;
      end
      if (cmd.bld_wr) begin
         wr_en          = 1'b1;
         wr_row[lvl_ff] = up_val;
         if (u_ff == top) begin
            u_in   = ID_W'(1);
            lvl_in = lvl_ff + KW'(1);
         end else begin
            u_in = u_ff + ID_W'(1);
         end
      end
      if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_row  = '0;
         clr_in  = clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff   <= u_in;
      v_ff   <= v_in;
      k_ff   <= k_in;
      lvl_ff <= lvl_in;
      dep_ff <= dep_in;
      eq_ff  <= eq_in;
      anc_ff <= anc_in;
   end

   // read ports follow the next u and v, so the data matches u_ff and v_ff
   always_ff @(posedge clock) begin
      if (wr_en) begin
         jump_mem[wr_addr] <= wr_row;
      end
      if (dwr_en) begin
         depth_mem[to_addr(u_ff)] <= dep_ff;
      end
      row_u_ff <= jump_mem[to_addr(u_in)];
      row_v_ff <= jump_mem[to_addr(v_in)];
      du_rd_ff <= depth_mem[to_addr(u_in)];
      dv_rd_ff <= depth_mem[to_addr(v_in)];
   end

endmodule
